/* rtl/core/bct_pkg.sv */
// Shared constants, codes and types for the binary curve tracer.
// Used by the channel interfaces, the serial divider and the top level.
package bct_pkg;

   localparam int MAX_PIXELS_DEFAULT = 65536;
   localparam int IDX_W  = 16;
   localparam int SIZE_W = 17;
   localparam int CONN_W = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [SIZE_W-1:0] SIZE_MAX = 17'd65536;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_START   = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK           = 2'd0,
      ERR_NOT_ENDPOINT = 2'd1,
      ERR_NEIGHBOURS   = 2'd2,
      ERR_NO_TRACE     = 2'd3
   } err_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_SIZE     = 2'd0,
      CSR_PLANE_SIZE   = 2'd1,
      CSR_IMAGE_SIZE   = 2'd2,
      CSR_CONNECTIVITY = 2'd3
   } csr_type;

   localparam logic [CONN_W-1:0] CONN_4  = 3'd0;
   localparam logic [CONN_W-1:0] CONN_8  = 3'd1;
   localparam logic [CONN_W-1:0] CONN_6  = 3'd2;
   localparam logic [CONN_W-1:0] CONN_18 = 3'd3;
   localparam logic [CONN_W-1:0] CONN_26 = 3'd4;

   // offset codes for one axis of the neighbour scan
   localparam logic [1:0] OFS_NEG  = 2'd0;
   localparam logic [1:0] OFS_ZERO = 2'd1;
   localparam logic [1:0] OFS_POS  = 2'd2;

   typedef struct packed {
      logic              start;
      logic [IDX_W-1:0]  dividend;
      logic [SIZE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [IDX_W-1:0]  quotient;
      logic [SIZE_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) r = SIZE_W'(1);
      else if (v > SIZE_MAX) r = SIZE_MAX;
      return r;
   endfunction

endpackage

/* rtl/core/bct_req_if.sv */
// Request channel of the binary curve tracer: op, pixel index and pixel value.
// Depends on bct_pkg for field widths.
interface bct_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                op;
   logic [bct_pkg::IDX_W-1:0] pixel_index;
   logic                      pixel_value;

   modport source (output valid, op, pixel_index, pixel_value, input ready);
   modport sink   (input valid, op, pixel_index, pixel_value, output ready);
endinterface

/* rtl/core/bct_rsp_if.sv */
// Result channel of the binary curve tracer: coordinates, last flag, error code.
// Depends on bct_pkg for field widths.
interface bct_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bct_pkg::IDX_W-1:0] x_coord;
   logic [bct_pkg::IDX_W-1:0] y_coord;
   logic [bct_pkg::IDX_W-1:0] z_coord;
   logic                      last_point;
   logic [1:0]                error_code;

   modport source (output valid, x_coord, y_coord, z_coord, last_point, error_code,
                   input ready);
   modport sink   (input valid, x_coord, y_coord, z_coord, last_point, error_code,
                   output ready);
endinterface

/* rtl/core/bct_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Depends on bct_pkg for the request and response structs.
module bct_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bct_pkg::div_req_type req,
   output bct_pkg::div_rsp_type rsp
);
   localparam int CNT_W = $clog2(bct_pkg::IDX_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              step_ff, step_in;
   logic [bct_pkg::IDX_W-1:0]     quo_ff, quo_in;
   logic [bct_pkg::SIZE_W-1:0]    rem_ff, rem_in;
   logic [bct_pkg::SIZE_W-1:0]    div_ff, div_in;
   logic [bct_pkg::SIZE_W-1:0]    trial;
   logic                          qbit;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      // remainder stays below the divisor, so it fits in the low bits
      trial = {rem_ff[bct_pkg::SIZE_W-2:0], quo_ff[bct_pkg::IDX_W-1]};
      qbit  = (trial >= div_ff);
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         div_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in  = qbit ? (trial - div_ff) : trial;
         quo_in  = {quo_ff[bct_pkg::IDX_W-2:0], qbit};
         step_in = step_ff + CNT_W'(1);
         if (step_ff == CNT_W'(bct_pkg::IDX_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;
endmodule

/* rtl/core/binary_curve_tracer.sv */
// Binary curve tracer: a one-bit image or volume held in an on-chip memory,
// loaded one pixel per item, and traced along a thin curve from an endpoint.
// Every start, and every advance during a trace, splits a point index into
// column, row and plane with a shared serial divider (three divisions) and
// then scans its 3x3x3 neighbourhood, one memory read per cycle. An advance
// handles the current and the next point. The memory is not cleared after
// reset: the user must see that every pixel is loaded before a trace reads
// it, and the block itself does not enforce this.
module binary_curve_tracer #(
   parameter int MAX_PIXELS = bct_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   bct_req_if.sink                       req_if,
   bct_rsp_if.source                     rsp_if,
   input  logic                          csr_write_enable,
   input  logic [bct_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bct_pkg::SIZE_W-1:0]    csr_write_data
);
   localparam int AW = $clog2(MAX_PIXELS);
   localparam int IW = bct_pkg::IDX_W;
   localparam int SW = bct_pkg::SIZE_W;
   localparam int CW = SW + 2;
   localparam logic [24:0] MAX_V = 25'(MAX_PIXELS);
   localparam logic [SW-1:0] MAX_N = SW'((MAX_PIXELS > 65536) ? 65536 : MAX_PIXELS);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIVA   = 6'b000010,
      ST_DIVB   = 6'b000100,
      ST_DIVC   = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_DECIDE = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      MODE_START    = 2'd0,
      MODE_CUR      = 2'd1,
      MODE_NXT      = 2'd2,
      MODE_NO_TRACE = 2'd3
   } mode_type;

   // configuration
   logic [SW-1:0] row_ff, plane_ff, image_ff;
   logic [bct_pkg::CONN_W-1:0] conn_ff;
   logic [SW-1:0] rs_eff, ps_eff, n_eff;
   logic [bct_pkg::CONN_W-1:0] conn_eff;
   logic [SW-1:0] n_clamp;

   // control and trace state
   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic          active_ff, active_in;
   logic [IW-1:0] prev_ff, prev_in, cur_ff, cur_in;
   logic [IW-1:0] pt_idx_ff, pt_idx_in, pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic [IW-1:0] pt_z_ff, pt_z_in, pt_p_ff, pt_p_in;
   logic          div_run_ff, div_run_in;

   // neighbour scan
   logic [1:0]    dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic          scan_end_ff, scan_end_in;
   logic          pend_v_ff, pend_v_in, pend_ctr_ff, pend_ctr_in;
   logic [IW-1:0] pend_j_ff, pend_j_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          ctr_obj_ff, ctr_obj_in;
   logic [IW-1:0] list0_ff, list0_in, list1_ff, list1_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [1:0]    rsp_err_ff, rsp_err_in;

   // memory
   logic          image_mem [MAX_PIXELS];
   logic          mem_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;

   bct_pkg::div_req_type div_req;
   bct_pkg::div_rsp_type div_rsp;

   logic accept;
   logic out_free;
   logic [1:0] lim;
   logic [1:0] mag;
   logic signed [CW-1:0] tx, trs, tps, xs, ppv, jv;
   logic signed [CW-1:0] rs_s, ps_s, n_s, x_s, p_s, i_s;
   logic issue_v, is_ctr;
   logic need1;
   logic [1:0] need;
   logic [IW-1:0] nxt;
   logic start_ok;

   bct_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // effective sizes
   always_comb begin
      conn_eff = (conn_ff > bct_pkg::CONN_26) ? bct_pkg::CONN_26 : conn_ff;
      rs_eff   = bct_pkg::clamp_size(row_ff);
      n_clamp  = bct_pkg::clamp_size(image_ff);
      n_eff    = (n_clamp > MAX_N) ? MAX_N : n_clamp;
      ps_eff   = (conn_eff < bct_pkg::CONN_6) ? n_eff : bct_pkg::clamp_size(plane_ff);
      case (conn_eff)
         bct_pkg::CONN_4, bct_pkg::CONN_6: lim = 2'd1;
         bct_pkg::CONN_18:                 lim = 2'd2;
         default:                          lim = 2'd3;
      endcase
   end

   // neighbour address for the current scan offset
   always_comb begin
      rs_s = CW'(signed'({2'b00, rs_eff}));
      ps_s = CW'(signed'({2'b00, ps_eff}));
      n_s  = CW'(signed'({2'b00, n_eff}));
      x_s  = CW'(signed'({3'b000, pt_x_ff}));
      p_s  = CW'(signed'({3'b000, pt_p_ff}));
      i_s  = CW'(signed'({3'b000, pt_idx_ff}));
      case (dx_ff)
         bct_pkg::OFS_NEG: tx = -CW'(signed'(2'sd1));
         bct_pkg::OFS_POS: tx = CW'(signed'(2'sd1));
         default:          tx = '0;
      endcase
      case (dy_ff)
         bct_pkg::OFS_NEG: trs = -rs_s;
         bct_pkg::OFS_POS: trs = rs_s;
         default:          trs = '0;
      endcase
      case (dz_ff)
         bct_pkg::OFS_NEG: tps = -ps_s;
         bct_pkg::OFS_POS: tps = ps_s;
         default:          tps = '0;
      endcase
      xs  = x_s + tx;
      ppv = p_s + tx + trs;
      jv  = i_s + tx + trs + tps;
      mag = 2'((dx_ff != bct_pkg::OFS_ZERO)) + 2'((dy_ff != bct_pkg::OFS_ZERO))
          + 2'((dz_ff != bct_pkg::OFS_ZERO));
      is_ctr  = (mag == 2'd0);
      issue_v = !scan_end_ff && (mag <= lim)
              && ((dz_ff == bct_pkg::OFS_ZERO) || (conn_eff >= bct_pkg::CONN_6))
              && (xs >= 0) && (xs < rs_s)
              && (ppv >= 0) && (ppv < ps_s)
              && (jv >= 0) && (jv < n_s);
      mem_ra = AW'(jv[IW-1:0]);
   end

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign mem_we   = accept && (req_if.op == bct_pkg::OP_LOAD)
                   && (25'(req_if.pixel_index) < MAX_V);
   assign mem_wa   = AW'(req_if.pixel_index);

   always_comb begin
      need1    = (prev_ff == cur_ff);
      need     = need1 ? 2'd1 : 2'd2;
      nxt      = (need1 || (list0_ff != prev_ff)) ? list0_ff : list1_ff;
      start_ok = ({1'b0, pt_idx_ff} < n_eff) && ctr_obj_ff && (cnt_ff == 2'd1);
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      active_in   = active_ff;
      prev_in     = prev_ff;
      cur_in      = cur_ff;
      pt_idx_in   = pt_idx_ff;
      pt_x_in     = pt_x_ff;
      pt_y_in     = pt_y_ff;
      pt_z_in     = pt_z_ff;
      pt_p_in     = pt_p_ff;
      div_run_in  = div_run_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      dz_in       = dz_ff;
      scan_end_in = scan_end_ff;
      pend_v_in   = 1'b0;
      pend_ctr_in = is_ctr;
      pend_j_in   = jv[IW-1:0];
      cnt_in      = cnt_ff;
      ctr_obj_in  = ctr_obj_ff;
      list0_in    = list0_ff;
      list1_in    = list1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_z_in    = rsp_z_ff;
      rsp_last_in = rsp_last_ff;
      rsp_err_in  = rsp_err_ff;
      div_req.start    = 1'b0;
      div_req.dividend = pt_idx_ff;
      div_req.divisor  = ps_eff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_if.op)
                  bct_pkg::OP_START: begin
                     mode_in   = MODE_START;
                     pt_idx_in = req_if.pixel_index;
                     state_in  = ST_DIVA;
                  end
                  bct_pkg::OP_ADVANCE: begin
                     if (active_ff) begin
                        mode_in   = MODE_CUR;
                        pt_idx_in = cur_ff;
                        state_in  = ST_DIVA;
                     end else begin
                        mode_in  = MODE_NO_TRACE;
                        state_in = ST_DECIDE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIVA, ST_DIVB, ST_DIVC: begin
            if (state_ff == ST_DIVA) begin
               div_req.divisor = ps_eff;
            end else begin
               div_req.divisor = rs_eff;
            end
            if (state_ff == ST_DIVC) begin
               div_req.dividend = pt_p_ff;
            end
            div_req.start = !div_run_ff;
            if (!div_run_ff) begin
               div_run_in = 1'b1;
            end else if (div_rsp.done) begin
               div_run_in = 1'b0;
               case (state_ff)
                  ST_DIVA: begin
                     pt_z_in  = div_rsp.quotient;
                     pt_p_in  = div_rsp.remainder[IW-1:0];
                     state_in = ST_DIVB;
                  end
                  ST_DIVB: begin
                     pt_x_in  = div_rsp.remainder[IW-1:0];
                     state_in = ST_DIVC;
                  end
                  default: begin
                     pt_y_in     = div_rsp.quotient;
                     dx_in       = bct_pkg::OFS_NEG;
                     dy_in       = bct_pkg::OFS_NEG;
                     dz_in       = bct_pkg::OFS_NEG;
                     scan_end_in = 1'b0;
                     cnt_in      = '0;
                     ctr_obj_in  = 1'b0;
                     state_in    = ST_SCAN;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // read issued this cycle, data checked the next
            pend_v_in = issue_v;
            if (pend_v_ff && mem_q_ff) begin
               if (pend_ctr_ff) begin
                  ctr_obj_in = 1'b1;
               end else begin
                  if (cnt_ff == 2'd0) list0_in = pend_j_ff;
                  if (cnt_ff == 2'd1) list1_in = pend_j_ff;
                  if (cnt_ff != 2'd3) cnt_in = cnt_ff + 2'd1;
               end
            end
            if (scan_end_ff) begin
               state_in = ST_DECIDE;
            end else if (dx_ff == bct_pkg::OFS_POS) begin
               dx_in = bct_pkg::OFS_NEG;
               if (dy_ff == bct_pkg::OFS_POS) begin
                  dy_in = bct_pkg::OFS_NEG;
                  if (dz_ff == bct_pkg::OFS_POS) scan_end_in = 1'b1;
                  else dz_in = dz_ff + 2'd1;
               end else begin
                  dy_in = dy_ff + 2'd1;
               end
            end else begin
               dx_in = dx_ff + 2'd1;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in    = ST_IDLE;
               rsp_x_in    = pt_x_ff;
               rsp_y_in    = pt_y_ff;
               rsp_z_in    = pt_z_ff;
               rsp_last_in = 1'b0;
               rsp_err_in  = bct_pkg::ERR_OK;
               rsp_valid_in = 1'b1;
               case (mode_ff)
                  MODE_START: begin
                     if (start_ok) begin
                        prev_in   = pt_idx_ff;
                        cur_in    = pt_idx_ff;
                        active_in = 1'b1;
                     end else begin
                        active_in  = 1'b0;
                        rsp_err_in = bct_pkg::ERR_NOT_ENDPOINT;
                     end
                  end
                  MODE_CUR: begin
                     if (cnt_ff != need) begin
                        active_in  = 1'b0;
                        rsp_err_in = bct_pkg::ERR_NEIGHBOURS;
                     end else begin
                        // step on; the result comes after the next point's scan
                        rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
                        prev_in   = cur_ff;
                        cur_in    = nxt;
                        pt_idx_in = nxt;
                        mode_in   = MODE_NXT;
                        state_in  = ST_DIVA;
                     end
                  end
                  MODE_NXT: begin
                     if (cnt_ff == 2'd1) begin
                        active_in   = 1'b0;
                        rsp_last_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_x_in   = '0;
                     rsp_y_in   = '0;
                     rsp_z_in   = '0;
                     rsp_err_in = bct_pkg::ERR_NO_TRACE;
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= 17'd256;
         plane_ff     <= 17'd65536;
         image_ff     <= 17'd65536;
         conn_ff      <= bct_pkg::CONN_8;
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_START;
         active_ff    <= 1'b0;
         prev_ff      <= '0;
         cur_ff       <= '0;
         div_run_ff   <= 1'b0;
         scan_end_ff  <= 1'b0;
         pend_v_ff    <= 1'b0;
         cnt_ff       <= '0;
         ctr_obj_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               bct_pkg::CSR_ROW_SIZE:   row_ff   <= csr_write_data;
               bct_pkg::CSR_PLANE_SIZE: plane_ff <= csr_write_data;
               bct_pkg::CSR_IMAGE_SIZE: image_ff <= csr_write_data;
               default: conn_ff <= csr_write_data[bct_pkg::CONN_W-1:0];
            endcase
         end
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         active_ff    <= active_in;
         prev_ff      <= prev_in;
         cur_ff       <= cur_in;
         div_run_ff   <= div_run_in;
         scan_end_ff  <= scan_end_in;
         pend_v_ff    <= pend_v_in;
         cnt_ff       <= cnt_in;
         ctr_obj_ff   <= ctr_obj_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pt_idx_ff   <= pt_idx_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      pt_z_ff     <= pt_z_in;
      pt_p_ff     <= pt_p_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      pend_ctr_ff <= pend_ctr_in;
      pend_j_ff   <= pend_j_in;
      list0_ff    <= list0_in;
      list1_ff    <= list1_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // image memory: one write port for loads, one registered read port for scans
   always_ff @(posedge clock) begin
      if (mem_we) begin
         image_mem[mem_wa] <= req_if.pixel_value;
      end
      mem_q_ff <= image_mem[mem_ra];
   end

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.x_coord    = rsp_x_ff;
   assign rsp_if.y_coord    = rsp_y_ff;
   assign rsp_if.z_coord    = rsp_z_ff;
   assign rsp_if.last_point = rsp_last_ff;
   assign rsp_if.error_code = rsp_err_ff;
endmodule

/* bench/bct_trace_checker.sv */
`timescale 1ns / 100ps
// Checker for the binary curve tracer: watches the request, result and register
// ports, keeps its own copy of the image and trace state, and compares results.
// Depends on bct_pkg and the bct_req_if / bct_rsp_if channel interfaces.
module bct_trace_checker (
   input  logic                          clock,
   input  logic                          reset,
   bct_req_if                            req_mon,
   bct_rsp_if                            rsp_mon,
   input  logic                          csr_write_enable,
   input  logic [bct_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bct_pkg::SIZE_W-1:0]    csr_write_data,
   output int                            fail_count,
   output int                            pending_points
);

   typedef struct packed {
      logic [15:0]      x;
      logic [15:0]      y;
      logic [15:0]      z;
      logic             last;
      bct_pkg::err_type err;
   } point_type;

   point_type   point_q[$];
   bit          pixel_mem[0:65535];
   int unsigned row_cfg, plane_cfg, image_cfg, conn_cfg;
   int unsigned prev_idx, cur_idx;
   bit          tracing;
   int unsigned nbr_list[26];

   function automatic int unsigned size_limit(int unsigned v);
      if (v == 0) return 1;
      if (v > 65536) return 65536;
      return v;
   endfunction

   function automatic int unsigned conn_mode();
      return conn_cfg > 4 ? 4 : conn_cfg;
   endfunction

   function automatic int unsigned pixel_count();
      return size_limit(image_cfg);
   endfunction

   function automatic int unsigned plane_len();
      return conn_mode() < 2 ? pixel_count() : size_limit(plane_cfg);
   endfunction

   // fills nbr_list in scan order (dz, dy, dx) and returns the object count
   function automatic int count_nbrs(int unsigned i);
      longint rs, ps, n, lim, zr, x, p, m, pp, j;
      int      c, cnt;
      rs = size_limit(row_cfg);
      ps = plane_len();
      n = pixel_count();
      c = conn_mode();
      lim = (c == 0 || c == 2) ? 1 : (c == 3 ? 2 : 3);
      zr = c < 2 ? 0 : 1;
      x = i % rs;
      p = i % ps;
      cnt = 0;
      for (longint dz = -zr; dz <= zr; dz++)
         for (longint dy = -1; dy <= 1; dy++)
            for (longint dx = -1; dx <= 1; dx++) begin
               m = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) + (dz < 0 ? -dz : dz);
               if (m == 0 || m > lim) continue;
               if (x + dx < 0 || x + dx >= rs) continue;
               pp = p + dx + dy * rs;
               if (pp < 0 || pp >= ps) continue;
               j = i + dx + dy * rs + dz * ps;
               if (j < 0 || j >= n || j > 65535) continue;
               if (pixel_mem[j]) begin
                  nbr_list[cnt] = 32'(j);
                  cnt++;
               end
            end
      return cnt;
   endfunction

   function automatic point_type make_point(int unsigned idx, bit last,
                                            bct_pkg::err_type err);
      point_type   pt;
      int unsigned rs, ps;
      rs = size_limit(row_cfg);
      ps = plane_len();
      pt.x = 16'(idx % rs);
      pt.y = 16'((idx % ps) / rs);
      pt.z = 16'(idx / ps);
      pt.last = last;
      pt.err = err;
      return pt;
   endfunction

   task automatic apply_request(bct_pkg::op_type op, int unsigned idx, bit val);
      int          cnt, need;
      int unsigned nxt;
      case (op)
         bct_pkg::OP_LOAD: begin
            pixel_mem[idx] = val;
         end
         bct_pkg::OP_START: begin
            if (idx < pixel_count() && pixel_mem[idx] && count_nbrs(idx) == 1) begin
               prev_idx = idx;
               cur_idx = idx;
               tracing = 1'b1;
               point_q.push_back(make_point(idx, 1'b0, bct_pkg::ERR_OK));
            end else begin
               tracing = 1'b0;
               point_q.push_back(make_point(idx, 1'b0, bct_pkg::ERR_NOT_ENDPOINT));
            end
         end
         bct_pkg::OP_ADVANCE: begin
            if (!tracing) begin
               point_q.push_back(make_point(0, 1'b0, bct_pkg::ERR_NO_TRACE));
            end else begin
               cnt = count_nbrs(cur_idx);
               need = (prev_idx == cur_idx) ? 1 : 2;
               if (cnt != need) begin
                  tracing = 1'b0;
                  point_q.push_back(make_point(cur_idx, 1'b0, bct_pkg::ERR_NEIGHBOURS));
               end else begin
                  if (need == 1) nxt = nbr_list[0];
                  else nxt = (nbr_list[0] == prev_idx) ? nbr_list[1] : nbr_list[0];
                  prev_idx = cur_idx;
                  cur_idx = nxt;
                  if (count_nbrs(nxt) == 1) begin
                     tracing = 1'b0;
                     point_q.push_back(make_point(nxt, 1'b1, bct_pkg::ERR_OK));
                  end else begin
                     point_q.push_back(make_point(nxt, 1'b0, bct_pkg::ERR_OK));
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         point_q.delete();
         prev_idx = 0;
         cur_idx = 0;
         tracing = 1'b0;
         row_cfg = 256;
         plane_cfg = 65536;
         image_cfg = 65536;
         conn_cfg = 1;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (point_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected point x=%0d y=%0d z=%0d last=%0d err=%0d", $time,
                        rsp_mon.x_coord, rsp_mon.y_coord, rsp_mon.z_coord,
                        rsp_mon.last_point, rsp_mon.error_code);
            end else begin
               want = point_q.pop_front();
               if (rsp_mon.x_coord !== want.x || rsp_mon.y_coord !== want.y ||
                   rsp_mon.z_coord !== want.z || rsp_mon.last_point !== want.last ||
                   rsp_mon.error_code !== want.err) begin
                  fail_count++;
                  $display("%0t: mismatch expected x=%0d y=%0d z=%0d last=%0d err=%0d", $time,
                           want.x, want.y, want.z, want.last, want.err);
                  $display("%0t:          actual   x=%0d y=%0d z=%0d last=%0d err=%0d", $time,
                           rsp_mon.x_coord, rsp_mon.y_coord, rsp_mon.z_coord,
                           rsp_mon.last_point, rsp_mon.error_code);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            apply_request(bct_pkg::op_type'(req_mon.op), 32'(req_mon.pixel_index),
                          req_mon.pixel_value);
         if (csr_write_enable) begin
            case (bct_pkg::csr_type'(csr_index))
               bct_pkg::CSR_ROW_SIZE:     row_cfg = 32'(csr_write_data);
               bct_pkg::CSR_PLANE_SIZE:   plane_cfg = 32'(csr_write_data);
               bct_pkg::CSR_IMAGE_SIZE:   image_cfg = 32'(csr_write_data);
               bct_pkg::CSR_CONNECTIVITY: conn_cfg = 32'(csr_write_data[2:0]);
               default: ;
            endcase
         end
      end
      pending_points <= point_q.size();
   end

   initial fail_count = 0;
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Top of the binary curve tracer bench: clock, reset, register writes, and
// item stimulus (image loads plus traces along random thin curves).
// Depends on bct_pkg, the channel interfaces, the RTL and bct_trace_checker.
module tb_top;

   logic                          clock;
   logic                          reset;
   logic                          csr_write_enable;
   logic [bct_pkg::CSR_IDX_W-1:0] csr_index;
   logic [bct_pkg::SIZE_W-1:0]    csr_write_data;
   int                            fail_count, pending_points;
   int                            item_count, phase_count;
   int                            rsp_stall = 0;
   bit                            quiet;
   bit                            curve_pix[0:255];

   bct_req_if req_ch();
   bct_rsp_if rsp_ch();

   binary_curve_tracer u_top (
      .clock(clock), .reset(reset), .req_if(req_ch.sink), .rsp_if(rsp_ch.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   bct_trace_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .fail_count(fail_count),
      .pending_points(pending_points)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("Timeout at %0t", $time);
      $display("Regression FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result-side back-pressure
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!quiet) rsp_stall <= pick_gap();
      end
   end

   task automatic send_item(bct_pkg::op_type op, int idx, bit val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.pixel_index <= 16'(idx);
      req_ch.pixel_value <= val;
      do @(posedge clock); while (!req_ch.ready);
      item_count++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_points != 0);
      // loads give no result; let the last one settle
      repeat (200) @(posedge clock);
   endtask

   task automatic set_config(logic [16:0] rs, logic [16:0] ps, logic [16:0] n,
                             logic [16:0] conn);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index <= bct_pkg::CSR_ROW_SIZE;
      csr_write_data <= rs;
      @(posedge clock);
      csr_index <= bct_pkg::CSR_PLANE_SIZE;
      csr_write_data <= ps;
      @(posedge clock);
      csr_index <= bct_pkg::CSR_IMAGE_SIZE;
      csr_write_data <= n;
      @(posedge clock);
      csr_index <= bct_pkg::CSR_CONNECTIVITY;
      csr_write_data <= conn;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      phase_count++;
   endtask

   function automatic int lim_size(int v);
      return v == 0 ? 1 : (v > 65536 ? 65536 : v);
   endfunction

   // random walk that mostly keeps its direction, giving thin curves
   task automatic draw_curve(int rs, int ps, int n, int conn,
                             output int head, output int tail, output int len);
      int c, lim, zr, x, p, j, target, dx, dy, dz, m;
      c = conn > 4 ? 4 : conn;
      lim = (c == 0 || c == 2) ? 1 : (c == 3 ? 2 : 3);
      zr = c < 2 ? 0 : 1;
      ps = c < 2 ? n : ps;
      for (int i = 0; i < 256; i++) curve_pix[i] = 1'b0;
      head = $urandom_range(0, n - 1);
      curve_pix[head] = 1'b1;
      tail = head;
      len = 1;
      target = $urandom_range(2, 14);
      dx = 0; dy = 0; dz = 0;
      for (int t = 0; t < 60 && len < target; t++) begin
         m = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) + (dz < 0 ? -dz : dz);
         if (m == 0 || $urandom_range(0, 9) < 3) begin
            do begin
               dx = $urandom_range(0, 2) - 1;
               dy = $urandom_range(0, 2) - 1;
               dz = zr ? $urandom_range(0, 2) - 1 : 0;
               m = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) + (dz < 0 ? -dz : dz);
            end while (m == 0 || m > lim);
         end
         x = tail % rs;
         p = tail % ps;
         j = tail + dx + dy * rs + dz * ps;
         if (x + dx < 0 || x + dx >= rs || p + dx + dy * rs < 0 ||
             p + dx + dy * rs >= ps || j < 0 || j >= n || curve_pix[j]) begin
            dx = 0; dy = 0; dz = 0;
         end else begin
            curve_pix[j] = 1'b1;
            tail = j;
            len++;
         end
      end
   endtask

   task automatic follow_curve(int from, int steps, int n);
      send_item(bct_pkg::OP_START, from, 1'b0);
      repeat (steps) begin
         if ($urandom_range(0, 29) == 0)
            send_item(bct_pkg::OP_LOAD, $urandom_range(0, n - 1), 1'($urandom_range(0, 1)));
         else if ($urandom_range(0, 39) == 0)
            send_item(bct_pkg::OP_UNUSED, $urandom_range(0, 65535),
                      1'($urandom_range(0, 1)));
         send_item(bct_pkg::OP_ADVANCE, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_phase(logic [16:0] rs, logic [16:0] ps, logic [16:0] n,
                            logic [16:0] conn);
      int head, tail, len, ne, rse, pse, from;
      set_config(rs, ps, n, conn);
      quiet = ($urandom_range(0, 3) == 0);
      rse = lim_size(int'(rs));
      pse = lim_size(int'(ps));
      ne = lim_size(int'(n));
      for (int k = 0; k < 2; k++) begin
         draw_curve(rse, pse, ne, int'(conn), head, tail, len);
         for (int i = 0; i < ne; i++) begin
            // noise pixels now and then
            if (!curve_pix[i] && $urandom_range(0, 49) == 0) curve_pix[i] = 1'b1;
            send_item(bct_pkg::OP_LOAD, i, curve_pix[i]);
            if ($urandom_range(0, 15) == 0)
               send_item(bct_pkg::OP_LOAD, $urandom_range(ne, 65535),
                         1'($urandom_range(0, 1)));
         end
         follow_curve(head, len + 1, ne);
         follow_curve(tail, len + 1, ne);
         from = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, ne - 1);
         follow_curve(from, $urandom_range(0, 4), ne);
      end
   endtask

   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      item_count = 0;
      phase_count = 0;
      csr_write_enable <= 1'b0;
      csr_index <= bct_pkg::CSR_ROW_SIZE;
      csr_write_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.op <= bct_pkg::OP_LOAD;
      req_ch.pixel_index <= '0;
      req_ch.pixel_value <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no trace yet, unused op, loads at the top of the store
      send_item(bct_pkg::OP_ADVANCE, 0, 1'b0);
      send_item(bct_pkg::OP_UNUSED, 16'hFFFF, 1'b1);
      send_item(bct_pkg::OP_LOAD, 16'hFFFF, 1'b1);
      send_item(bct_pkg::OP_LOAD, 16'hFFFF, 1'b0);
      send_item(bct_pkg::OP_ADVANCE, 16'hFFFF, 1'b1);

      // full-size image, row of 65536: only the loaded head of the row is traced
      set_config(17'd65536, 17'd1, 17'd65536, 17'(bct_pkg::CONN_4));
      for (int i = 0; i < 8; i++) send_item(bct_pkg::OP_LOAD, i, i < 6);
      send_item(bct_pkg::OP_START, 3, 1'b0);
      follow_curve(0, 6, 6);
      send_item(bct_pkg::OP_START, 65535, 1'b0);

      // degenerate sizes: zero acts as one
      set_config(17'd0, 17'd0, 17'd0, 17'(bct_pkg::CONN_8));
      send_item(bct_pkg::OP_LOAD, 0, 1'b1);
      send_item(bct_pkg::OP_START, 0, 1'b0);
      send_item(bct_pkg::OP_START, 1, 1'b0);
      send_item(bct_pkg::OP_ADVANCE, 0, 1'b0);

      run_phase(17'd8, 17'd64, 17'd64, 17'(bct_pkg::CONN_8));
      run_phase(17'd8, 17'd64, 17'd64, 17'(bct_pkg::CONN_4));
      run_phase(17'd4, 17'd16, 17'd64, 17'(bct_pkg::CONN_6));
      run_phase(17'd4, 17'd16, 17'd64, 17'(bct_pkg::CONN_18));
      run_phase(17'd4, 17'd16, 17'd64, 17'(bct_pkg::CONN_26));
      run_phase(17'h1FFFF, 17'h1FFFF, 17'd40, 17'd7);
      run_phase(17'd1, 17'd3, 17'd30, 17'(bct_pkg::CONN_26));
      while (item_count < 1300) begin
         int rs;
         rs = $urandom_range(1, 12);
         run_phase(17'(rs), 17'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 60)
                                                             : rs * $urandom_range(1, 5)),
                   17'($urandom_range(rs, 120)), 17'($urandom_range(0, 7)));
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_points != 0);
      repeat (400) @(posedge clock);
      $display("Ran %0d items over %0d register settings (2D and 3D neighbourhoods)",
               item_count, phase_count);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d failures", fail_count);
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

/* binary_curve_tracer.f */
rtl/core/bct_pkg.sv
rtl/core/bct_req_if.sv
rtl/core/bct_rsp_if.sv
rtl/core/bct_div.sv
rtl/core/binary_curve_tracer.sv
bench/bct_trace_checker.sv
bench/tb_top.sv
